>>> rtl/pgg_pkg.sv
// Package for the palette gradient generator: widths, entry-class constants,
// the queue descriptor type and the divide-by-3825 reciprocal helper.
// No dependencies.
package pgg_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int CH_W        = 5;
  localparam int NUM_CH      = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Weighted channel product f*w*31 is at most 255*15*31 = 118575.
  localparam int PROD_W      = 17;
  // floor(x/3825) == (x*RECIP_MUL) >> RECIP_SHIFT for every x below 2^17.
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 18'd140359;

  localparam logic [IDX_W-1:0] LAST_IDX         = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] BLEND_FIRST      = IDX_W'(4);
  localparam logic [IDX_W-1:0] HARD_FLAG_FIRST  = IDX_W'(8);
  localparam logic [IDX_W-1:0] HARD_PLAIN_FIRST = IDX_W'(12);
  localparam logic [3:0]       SEMI_SLOT        = 4'hf;
  localparam logic [15:0]      NONZERO_WORD     = 16'h0400;

  typedef struct packed {
    logic [3:0]  slot;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic        hard;  // hard-edged in-game form
    logic        semi;  // slot carries the semi-transparency flag
  } pgg_desc_t;

  // Quotient of a weighted product by 3825; the result never exceeds 31.
  function automatic logic [CH_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
    logic [PROD_W+RECIP_W-1:0] p;
    p = PROD_W'(x) * RECIP_MUL;
    return p[RECIP_SHIFT +: CH_W];
  endfunction

endpackage

>>> rtl/pgg_in_if.sv
// Input channel of the palette gradient generator: valid/ready plus one
// palette request. No dependencies.
interface pgg_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  palette_slot;
  logic [31:0] fore_color;
  logic [23:0] back_color;
  logic        in_game_mode;

  modport source (output valid, palette_slot, fore_color, back_color, in_game_mode,
                  input ready);
  modport sink   (input valid, palette_slot, fore_color, back_color, in_game_mode,
                  output ready);
endinterface

>>> rtl/pgg_out_if.sv
// Result channel of the palette gradient generator: valid/ready plus one
// palette entry word. Depends on pgg_pkg.
interface pgg_out_if;
  import pgg_pkg::*;
  logic             valid;
  logic             ready;
  logic [3:0]       slot_out;
  logic [IDX_W-1:0] entry_index;
  logic [15:0]      entry_word;
  logic             last_entry;

  modport source (output valid, slot_out, entry_index, entry_word, last_entry,
                  input ready);
  modport sink   (input valid, slot_out, entry_index, entry_word, last_entry,
                  output ready);
endinterface

>>> rtl/pgg_front.sv
// Front end: accepts palette requests, classifies them (hard-edged form,
// semi-transparent slot) and holds them in a two-entry queue.
// Depends on pgg_pkg and pgg_in_if.
module pgg_front (
  input  logic              clk,
  input  logic              rst_n,
  pgg_in_if.sink            in_chan,
  output pgg_pkg::pgg_desc_t head,
  output logic              head_v,
  input  logic              pop
);
  import pgg_pkg::*;

  pgg_desc_t         q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  pgg_desc_t         desc;

  always_comb begin
    desc.slot     = in_chan.palette_slot;
    desc.fore_rgb = in_chan.fore_color[23:0];
    desc.back_rgb = in_chan.back_color;
    desc.hard     = in_chan.in_game_mode && (in_chan.fore_color[31:24] == 8'd0);
    desc.semi     = (in_chan.palette_slot == SEMI_SLOT);
  end

  assign in_chan.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign head_v        = (count_r != '0);
  assign head          = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= desc;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("palette request queue overflow");

  a_pop_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_v)
    else $error("palette request popped from an empty queue");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue fill count lost a pushed request");

endmodule

>>> rtl/pgg_back.sv
// Back end: walks the sixteen entries of the request at the queue head,
// blends the channels in a two-stage pipeline and drives the output register.
// Depends on pgg_pkg and pgg_out_if.
module pgg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pgg_pkg::pgg_desc_t head,
  input  logic               head_v,
  output logic               pop,
  pgg_out_if.source          out_chan
);
  import pgg_pkg::*;

  logic             adv, issue;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] wf, wb;
  logic             clear, flag;
  logic [PROD_W-1:0] xf [NUM_CH];
  logic [PROD_W-1:0] xb [NUM_CH];

  // Stage 1: weighted products.
  logic              s1_v_r;
  logic [3:0]        s1_slot_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_hard_r, s1_clear_r, s1_flag_r;
  logic [PROD_W-1:0] s1_xf_r [NUM_CH];
  logic [PROD_W-1:0] s1_xb_r [NUM_CH];

  // Stage 2: five-bit channels.
  logic              s2_v_r;
  logic [3:0]        s2_slot_r;
  logic [IDX_W-1:0]  s2_idx_r;
  logic              s2_hard_r, s2_clear_r, s2_flag_r;
  logic [CH_W-1:0]   s2_ch_r [NUM_CH];
  logic [15:0]       word;

  // Output register.
  logic              out_v_r;
  logic [3:0]        out_slot_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [15:0]       out_word_r;
  logic              out_last_r;
  logic              out_hard_r;

  assign adv   = !out_v_r || out_chan.ready;
  assign issue = head_v && adv;
  assign pop   = issue && (cnt_r == LAST_IDX);

  always_comb begin
    // The hard-edged form only ever uses the full foreground weight.
    wf      = head.hard ? LAST_IDX : cnt_r;
    wb      = LAST_IDX - wf;
    clear   = head.hard ? (cnt_r < HARD_FLAG_FIRST) : (cnt_r < BLEND_FIRST);
    flag    = head.hard ? (cnt_r < HARD_PLAIN_FIRST) : head.semi;
    cnt_nxt = issue ? cnt_r + 1'b1 : cnt_r;
    for (int c = 0; c < NUM_CH; c++) begin
      xf[c] = PROD_W'(head.fore_rgb[8*c +: 8]) * PROD_W'(wf) * PROD_W'(31);
      xb[c] = PROD_W'(head.back_rgb[8*c +: 8]) * PROD_W'(wb) * PROD_W'(31);
    end
  end

  always_comb begin
    word = {s2_flag_r, s2_ch_r[0], s2_ch_r[1], s2_ch_r[2]};
    if (s2_clear_r) begin
      word = '0;
    end else if (word == '0) begin
      word = NONZERO_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (adv) begin
        s1_v_r  <= issue;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_slot_r  <= head.slot;
      s1_idx_r   <= cnt_r;
      s1_hard_r  <= head.hard;
      s1_clear_r <= clear;
      s1_flag_r  <= flag;
      for (int c = 0; c < NUM_CH; c++) begin
        s1_xf_r[c] <= xf[c];
        s1_xb_r[c] <= xb[c];
      end

      s2_slot_r  <= s1_slot_r;
      s2_idx_r   <= s1_idx_r;
      s2_hard_r  <= s1_hard_r;
      s2_clear_r <= s1_clear_r;
      s2_flag_r  <= s1_flag_r;
      for (int c = 0; c < NUM_CH; c++) begin
        s2_ch_r[c] <= div_full_scale(s1_xf_r[c]) + div_full_scale(s1_xb_r[c]);
      end

      out_slot_r <= s2_slot_r;
      out_idx_r  <= s2_idx_r;
      out_word_r <= word;
      out_last_r <= (s2_idx_r == LAST_IDX);
      out_hard_r <= s2_hard_r;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.slot_out    = out_slot_r;
  assign out_chan.entry_index = out_idx_r;
  assign out_chan.entry_word  = out_word_r;
  assign out_chan.last_entry  = out_last_r;

  a_pop_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> cnt_r == '0)
    else $error("entry counter did not restart after the last entry");

  a_zero_only_transparent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_word_r == '0) |->
      (out_idx_r < BLEND_FIRST || (out_hard_r && out_idx_r < HARD_FLAG_FIRST)))
    else $error("non-transparent palette entry came out as zero");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_chan.ready) |=> (out_v_r && $stable(out_word_r)))
    else $error("stalled palette entry changed");

endmodule

>>> rtl/palette_gradient_generator_unit.sv
// Top level of the palette gradient generator: request front end, queue and
// entry pipeline. Depends on pgg_pkg, pgg_in_if, pgg_out_if, pgg_front, pgg_back.
//
// Usage:
//   in_chan carries one palette request per word: slot, foreground color with
//   opacity byte, background color and the in-game flag. out_chan returns the
//   sixteen RGB555 entries of that palette, entry 0 first, one word each, with
//   last_entry marking entry 15.
//   An accepted request is written into the queue; each of its entries then
//   passes stage 1, stage 2 and the output register. The pipeline produces
//   one entry per cycle while out_chan is ready, so this single entry pipeline
//   sets the request rate. Requests back to back keep it busy with no gap
//   between palettes.
//   A two-entry request queue sits between the front end and the pipeline, so
//   in_chan keeps accepting while an earlier palette is still being emitted.
//   When a word waits on out_chan with ready low, the whole entry pipeline
//   holds and that word stays on the port; in_chan.ready drops once the queue
//   is full.
//   Reset (rst_n low at a clock edge) empties the queue and the pipeline and
//   restarts the entry counter; requests and entries in flight are dropped.
module palette_gradient_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  pgg_in_if.sink     in_chan,
  pgg_out_if.source  out_chan
);
  import pgg_pkg::*;

  // Queue head as seen by the entry pipeline.
  pgg_desc_t head;
  logic      head_v;
  logic      pop;

  pgg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .head    (head),
    .head_v  (head_v),
    .pop     (pop)
  );

  // The pipeline pops the head when it issues the last entry of a palette.
  pgg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_v   (head_v),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
